[design/hsvargb_pkg.sv]
// shared types and constants for the hsv to argb pixel converter
// no dependencies; imported by every module of the block
package hsvargb_pkg;

  // field widths
  localparam int unsigned HUE_W    = 15;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CHROMA_W = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned NUM_CHAN = 3;

  // hue fraction bits by default (degrees times 64)
  localparam int unsigned HUE_FRAC_BITS_DEF = 6;

  // geometry of the colour wheel and the unit scale
  localparam int unsigned SECTOR_DEG = 60;
  localparam int unsigned SECTORS    = 6;
  localparam int unsigned UNIT_SCALE = 255;

  // reciprocal for hue degrees / 60, exact after one correction for 15-bit inputs
  localparam int unsigned DIV60_SHIFT = 21;
  localparam int unsigned DIV60_MUL   = (1 << DIV60_SHIFT) / SECTOR_DEG;
  localparam int unsigned DIV60_MUL_W = $clog2(DIV60_MUL + 1);

  // reciprocal for sector count / 6, exact after one correction below 1024
  localparam int unsigned DIV6_SHIFT = 13;
  localparam int unsigned DIV6_MUL   = (1 << DIV6_SHIFT) / SECTORS;
  localparam int unsigned DIV6_MUL_W = $clog2(DIV6_MUL + 1);

  // chroma times weight after dropping the hue fraction bits: at most 65025 * 60
  localparam int unsigned XSRC_W       = 22;
  localparam int unsigned DIV60W_SHIFT = 28;
  localparam int unsigned DIV60W_MUL   = (1 << DIV60W_SHIFT) / SECTOR_DEG;
  localparam int unsigned DIV60W_MUL_W = $clog2(DIV60W_MUL + 1);

  // reciprocal for channel / 255, exact after one correction for 16-bit inputs
  localparam int unsigned DIV255_SHIFT = 16;
  localparam int unsigned DIV255_MUL   = 257;
  localparam int unsigned DIV255_MUL_W = $clog2(DIV255_MUL + 1);

  // register stages from accepted transaction to result strobe
  localparam int unsigned PIPE_DEPTH = 10;

  // sixty-degree sectors of the colour wheel
  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_e;

endpackage

[design/hsvargb_sector.sv]
// hue split into sector and weight, plus chroma and offset, four register stages
// depends on hsvargb_pkg
module hsvargb_sector #(
  parameter int unsigned HueFracBits = hsvargb_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [hsvargb_pkg::HUE_W-1:0]     hue_i,
  input  logic [hsvargb_pkg::BYTE_W-1:0]    saturation_i,
  input  logic [hsvargb_pkg::BYTE_W-1:0]    brightness_i,
  input  logic [hsvargb_pkg::BYTE_W-1:0]    alpha_i,
  output logic                              valid_o,
  output hsvargb_pkg::sector_e              sector_o,
  output logic [$clog2((hsvargb_pkg::SECTOR_DEG << HueFracBits) + 1)-1:0] weight_o,
  output logic [hsvargb_pkg::CHROMA_W-1:0]  chroma_o,
  output logic [hsvargb_pkg::CHROMA_W-1:0]  offset_o,
  output logic [hsvargb_pkg::BYTE_W-1:0]    alpha_o
);
  import hsvargb_pkg::*;

  localparam int unsigned Span   = SECTOR_DEG << HueFracBits;
  localparam int unsigned SpanW  = $clog2(Span + 1);
  localparam int unsigned FracW  = $clog2(Span);
  localparam int unsigned SegW   = HUE_W - HueFracBits;
  localparam int unsigned QuoW   = $clog2((((2 ** HUE_W) - 1) >> HueFracBits) / SECTOR_DEG + 1);
  localparam int unsigned ProdAW = SegW + DIV60_MUL_W;
  localparam int unsigned ProdBW = QuoW + DIV6_MUL_W;
  localparam int unsigned RemW   = $clog2(2 * SECTOR_DEG);
  localparam int unsigned ResW   = $clog2(SECTOR_DEG);
  localparam int unsigned SecW   = $clog2(2 * SECTORS);
  localparam int unsigned ModW   = (QuoW > SecW) ? QuoW : SecW;
  localparam logic [HUE_W-1:0] LowMask = HUE_W'((1 << HueFracBits) - 1);

  // stage a registers
  logic                valid_a_q;
  logic [ProdAW-1:0]   prod_a_q;
  logic [SegW-1:0]     seg_a_q;
  logic [HUE_W-1:0]    low_a_q;
  logic [CHROMA_W-1:0] chroma_a_q;
  logic [BYTE_W-1:0]   bright_a_q;
  logic [BYTE_W-1:0]   alpha_a_q;

  // stage b registers
  logic                valid_b_q;
  logic [QuoW-1:0]     quo_b_d, quo_b_q;
  logic [FracW-1:0]    frac_b_d, frac_b_q;
  logic [CHROMA_W-1:0] offset_b_d, offset_b_q;
  logic [CHROMA_W-1:0] chroma_b_q;
  logic [BYTE_W-1:0]   alpha_b_q;

  // stage c registers
  logic                valid_c_q;
  logic [ProdBW-1:0]   prod_c_q;
  logic [QuoW-1:0]     quo_c_q;
  logic [FracW-1:0]    frac_c_q;
  logic [CHROMA_W-1:0] offset_c_q;
  logic [CHROMA_W-1:0] chroma_c_q;
  logic [BYTE_W-1:0]   alpha_c_q;

  // stage d registers
  logic                valid_d_q;
  sector_e             sector_d_d, sector_d_q;
  logic [SpanW-1:0]    weight_d_d, weight_d_q;
  logic [CHROMA_W-1:0] offset_d_q;
  logic [CHROMA_W-1:0] chroma_d_q;
  logic [BYTE_W-1:0]   alpha_d_q;

  // stage b working values
  logic [QuoW-1:0]     quo_est;
  logic [RemW-1:0]     rem_est;
  logic [ResW-1:0]     residue;

  // stage d working values
  logic [ModW-1:0]     six_est;
  logic [SecW-1:0]     sec_est;
  logic [SecW-1:0]     sec_fix;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
      valid_d_q <= valid_c_q;
    end
  end

  // stage a: degree count times reciprocal of sixty, chroma product
  always_ff @(posedge clk_i) begin
    seg_a_q    <= SegW'(hue_i >> HueFracBits);
    prod_a_q   <= ProdAW'(hue_i >> HueFracBits) * ProdAW'(DIV60_MUL);
    low_a_q    <= hue_i & LowMask;
    chroma_a_q <= CHROMA_W'(brightness_i) * CHROMA_W'(saturation_i);
    bright_a_q <= brightness_i;
    alpha_a_q  <= alpha_i;
  end

  // stage b: correct the sixty quotient, rebuild the fraction, form the offset
  always_comb begin
    quo_est = QuoW'(prod_a_q >> DIV60_SHIFT);
    rem_est = RemW'(seg_a_q - SegW'(quo_est) * SegW'(SECTOR_DEG));
    if (rem_est >= RemW'(SECTOR_DEG)) begin
      quo_b_d = quo_est + QuoW'(1);
      residue = ResW'(rem_est - RemW'(SECTOR_DEG));
    end else begin
      quo_b_d = quo_est;
      residue = ResW'(rem_est);
    end
    frac_b_d   = FracW'((HUE_W'(residue) << HueFracBits) | low_a_q);
    offset_b_d = CHROMA_W'(bright_a_q) * CHROMA_W'(UNIT_SCALE) - chroma_a_q;
  end

  always_ff @(posedge clk_i) begin
    quo_b_q    <= quo_b_d;
    frac_b_q   <= frac_b_d;
    offset_b_q <= offset_b_d;
    chroma_b_q <= chroma_a_q;
    alpha_b_q  <= alpha_a_q;
  end

  // stage c: sector count times reciprocal of six
  always_ff @(posedge clk_i) begin
    prod_c_q   <= ProdBW'(quo_b_q) * ProdBW'(DIV6_MUL);
    quo_c_q    <= quo_b_q;
    frac_c_q   <= frac_b_q;
    offset_c_q <= offset_b_q;
    chroma_c_q <= chroma_b_q;
    alpha_c_q  <= alpha_b_q;
  end

  // stage d: sector count modulo six, weight mirrored in odd sectors
  always_comb begin
    six_est = ModW'(prod_c_q >> DIV6_SHIFT);
    sec_est = SecW'(ModW'(quo_c_q) - six_est * ModW'(SECTORS));
    if (sec_est >= SecW'(SECTORS)) begin
      sec_fix = sec_est - SecW'(SECTORS);
    end else begin
      sec_fix = sec_est;
    end
    sector_d_d = sector_e'(3'(sec_fix));
    if (sec_fix[0]) begin
      weight_d_d = SpanW'(Span) - SpanW'(frac_c_q);
    end else begin
      weight_d_d = SpanW'(frac_c_q);
    end
  end

  always_ff @(posedge clk_i) begin
    sector_d_q <= sector_d_d;
    weight_d_q <= weight_d_d;
    offset_d_q <= offset_c_q;
    chroma_d_q <= chroma_c_q;
    alpha_d_q  <= alpha_c_q;
  end

  assign valid_o  = valid_d_q;
  assign sector_o = sector_d_q;
  assign weight_o = weight_d_q;
  assign chroma_o = chroma_d_q;
  assign offset_o = offset_d_q;
  assign alpha_o  = alpha_d_q;

  // weight never exceeds one sector span
  a_weight_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (weight_o <= SpanW'(Span)))
    else $error("sector weight beyond span");

  // chroma and offset together make brightness at full scale
  a_offset_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((CHROMA_W'(offset_o + chroma_o)) ==
                 (CHROMA_W'($past(brightness_i, 4)) * CHROMA_W'(UNIT_SCALE))))
    else $error("offset and chroma disagree with brightness");

endmodule

[design/hsvargb_mix.sv]
// second colour component x and placement of chroma, x and offset, four register stages
// depends on hsvargb_pkg
module hsvargb_mix #(
  parameter int unsigned HueFracBits = hsvargb_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  hsvargb_pkg::sector_e              sector_i,
  input  logic [$clog2((hsvargb_pkg::SECTOR_DEG << HueFracBits) + 1)-1:0] weight_i,
  input  logic [hsvargb_pkg::CHROMA_W-1:0]  chroma_i,
  input  logic [hsvargb_pkg::CHROMA_W-1:0]  offset_i,
  input  logic [hsvargb_pkg::BYTE_W-1:0]    alpha_i,
  output logic                              valid_o,
  output logic [hsvargb_pkg::CHROMA_W-1:0]  red_o,
  output logic [hsvargb_pkg::CHROMA_W-1:0]  green_o,
  output logic [hsvargb_pkg::CHROMA_W-1:0]  blue_o,
  output logic [hsvargb_pkg::BYTE_W-1:0]    alpha_o
);
  import hsvargb_pkg::*;

  localparam int unsigned Span   = SECTOR_DEG << HueFracBits;
  localparam int unsigned SpanW  = $clog2(Span + 1);
  localparam int unsigned ProdCW = CHROMA_W + SpanW;
  localparam int unsigned ProdDW = XSRC_W + DIV60W_MUL_W;

  // stage e registers
  logic                valid_e_q;
  logic [ProdCW-1:0]   prod_e_q;
  sector_e             sector_e_q;
  logic [CHROMA_W-1:0] chroma_e_q;
  logic [CHROMA_W-1:0] offset_e_q;
  logic [BYTE_W-1:0]   alpha_e_q;

  // stage f registers
  logic                valid_f_q;
  logic [XSRC_W-1:0]   scaled_f_q;
  logic [ProdDW-1:0]   prod_f_q;
  sector_e             sector_f_q;
  logic [CHROMA_W-1:0] chroma_f_q;
  logic [CHROMA_W-1:0] offset_f_q;
  logic [BYTE_W-1:0]   alpha_f_q;

  // stage g registers
  logic                valid_g_q;
  logic [CHROMA_W-1:0] x_g_d, x_g_q;
  sector_e             sector_g_q;
  logic [CHROMA_W-1:0] chroma_g_q;
  logic [CHROMA_W-1:0] offset_g_q;
  logic [BYTE_W-1:0]   alpha_g_q;

  // stage h registers
  logic                valid_h_q;
  logic [CHROMA_W-1:0] red_h_d, red_h_q;
  logic [CHROMA_W-1:0] green_h_d, green_h_q;
  logic [CHROMA_W-1:0] blue_h_d, blue_h_q;
  logic [BYTE_W-1:0]   alpha_h_q;

  // working values
  logic [XSRC_W-1:0]   scaled;
  logic [CHROMA_W-1:0] x_est;
  logic [XSRC_W-1:0]   x_rem;
  logic [CHROMA_W-1:0] red_p, green_p, blue_p;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_e_q <= 1'b0;
      valid_f_q <= 1'b0;
      valid_g_q <= 1'b0;
      valid_h_q <= 1'b0;
    end else begin
      valid_e_q <= valid_i;
      valid_f_q <= valid_e_q;
      valid_g_q <= valid_f_q;
      valid_h_q <= valid_g_q;
    end
  end

  // stage e: chroma times sector weight
  always_ff @(posedge clk_i) begin
    prod_e_q   <= ProdCW'(chroma_i) * ProdCW'(weight_i);
    sector_e_q <= sector_i;
    chroma_e_q <= chroma_i;
    offset_e_q <= offset_i;
    alpha_e_q  <= alpha_i;
  end

  // stage f: drop hue fraction bits, multiply by reciprocal of sixty
  assign scaled = XSRC_W'(prod_e_q >> HueFracBits);

  always_ff @(posedge clk_i) begin
    scaled_f_q <= scaled;
    prod_f_q   <= ProdDW'(scaled) * ProdDW'(DIV60W_MUL);
    sector_f_q <= sector_e_q;
    chroma_f_q <= chroma_e_q;
    offset_f_q <= offset_e_q;
    alpha_f_q  <= alpha_e_q;
  end

  // stage g: one correction step gives the truncated quotient
  always_comb begin
    x_est = CHROMA_W'(prod_f_q >> DIV60W_SHIFT);
    x_rem = scaled_f_q - XSRC_W'(x_est) * XSRC_W'(SECTOR_DEG);
    if (x_rem >= XSRC_W'(SECTOR_DEG)) begin
      x_g_d = x_est + CHROMA_W'(1);
    end else begin
      x_g_d = x_est;
    end
  end

  always_ff @(posedge clk_i) begin
    x_g_q      <= x_g_d;
    sector_g_q <= sector_f_q;
    chroma_g_q <= chroma_f_q;
    offset_g_q <= offset_f_q;
    alpha_g_q  <= alpha_f_q;
  end

  // stage h: place chroma and x by sector, add the offset
  always_comb begin
    red_p   = '0;
    green_p = '0;
    blue_p  = '0;
    case (sector_g_q)
      SEC_RED_YELLOW: begin
        red_p   = chroma_g_q;
        green_p = x_g_q;
      end
      SEC_YELLOW_GREEN: begin
        red_p   = x_g_q;
        green_p = chroma_g_q;
      end
      SEC_GREEN_CYAN: begin
        green_p = chroma_g_q;
        blue_p  = x_g_q;
      end
      SEC_CYAN_BLUE: begin
        green_p = x_g_q;
        blue_p  = chroma_g_q;
      end
      SEC_BLUE_MAGENTA: begin
        red_p  = x_g_q;
        blue_p = chroma_g_q;
      end
      SEC_MAGENTA_RED: begin
        red_p  = chroma_g_q;
        blue_p = x_g_q;
      end
      default: begin
        red_p  = chroma_g_q;
        blue_p = x_g_q;
      end
    endcase
    red_h_d   = red_p + offset_g_q;
    green_h_d = green_p + offset_g_q;
    blue_h_d  = blue_p + offset_g_q;
  end

  always_ff @(posedge clk_i) begin
    red_h_q   <= red_h_d;
    green_h_q <= green_h_d;
    blue_h_q  <= blue_h_d;
    alpha_h_q <= alpha_g_q;
  end

  assign valid_o = valid_h_q;
  assign red_o   = red_h_q;
  assign green_o = green_h_q;
  assign blue_o  = blue_h_q;
  assign alpha_o = alpha_h_q;

  // the second component never exceeds chroma
  a_x_below_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_g_q |-> (x_g_q <= chroma_g_q))
    else $error("second colour component above chroma");

endmodule

[design/hsvargb_scale.sv]
// per-channel truncating divide by 255 and argb8888 packing, two register stages
// depends on hsvargb_pkg
module hsvargb_scale (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [hsvargb_pkg::CHROMA_W-1:0]  red_i,
  input  logic [hsvargb_pkg::CHROMA_W-1:0]  green_i,
  input  logic [hsvargb_pkg::CHROMA_W-1:0]  blue_i,
  input  logic [hsvargb_pkg::BYTE_W-1:0]    alpha_i,
  output logic                              valid_o,
  output logic [hsvargb_pkg::WORD_W-1:0]    argb_word_o
);
  import hsvargb_pkg::*;

  localparam int unsigned ProdW = CHROMA_W + DIV255_MUL_W;

  logic [CHROMA_W-1:0] chan_in [NUM_CHAN];

  // stage i registers
  logic                valid_i_q;
  logic [CHROMA_W-1:0] sum_i_q [NUM_CHAN];
  logic [BYTE_W-1:0]   est_i_d [NUM_CHAN];
  logic [BYTE_W-1:0]   est_i_q [NUM_CHAN];
  logic [BYTE_W-1:0]   alpha_i_q;

  // stage j registers
  logic                valid_j_q;
  logic [BYTE_W-1:0]   byte_j_d [NUM_CHAN];
  logic [WORD_W-1:0]   word_j_q;

  logic [CHROMA_W-1:0] chan_rem [NUM_CHAN];

  assign chan_in[0] = red_i;
  assign chan_in[1] = green_i;
  assign chan_in[2] = blue_i;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i_q <= 1'b0;
      valid_j_q <= 1'b0;
    end else begin
      valid_i_q <= valid_i;
      valid_j_q <= valid_i_q;
    end
  end

  // stage i: quotient estimate by reciprocal of 255
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      est_i_d[c] = BYTE_W'((ProdW'(chan_in[c]) * ProdW'(DIV255_MUL)) >> DIV255_SHIFT);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum_i_q[c] <= chan_in[c];
      est_i_q[c] <= est_i_d[c];
    end
    alpha_i_q <= alpha_i;
  end

  // stage j: one correction step, then pack alpha, red, green, blue
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      chan_rem[c] = sum_i_q[c] - CHROMA_W'(est_i_q[c]) * CHROMA_W'(UNIT_SCALE);
      if (chan_rem[c] >= CHROMA_W'(UNIT_SCALE)) begin
        byte_j_d[c] = est_i_q[c] + BYTE_W'(1);
      end else begin
        byte_j_d[c] = est_i_q[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_j_q <= {alpha_i_q, byte_j_d[0], byte_j_d[1], byte_j_d[2]};
  end

  assign valid_o     = valid_j_q;
  assign argb_word_o = word_j_q;

endmodule

[design/hsv_to_argb_pixel.sv]
// top level of the hsv to argb8888 pixel converter
// depends on hsvargb_pkg, hsvargb_sector, hsvargb_mix and hsvargb_scale
//
// Converts one hsv pixel with alpha per clock cycle into a packed argb8888 word.
// A transaction is taken on every cycle with start high; busy is never raised,
// since the ten-stage pipeline advances every cycle and holds no item back.
// Each result appears on argb_word_o for one cycle with done_o high, in the order
// of the starts, once it has passed the pipeline; the receiver must take it then.
// Hue wraps modulo a full turn; there is no state beyond the pipeline itself.
module hsv_to_argb_pixel #(
  parameter int unsigned HueFracBits = hsvargb_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [hsvargb_pkg::HUE_W-1:0]   hue_i,
  input  logic [hsvargb_pkg::BYTE_W-1:0]  saturation_i,
  input  logic [hsvargb_pkg::BYTE_W-1:0]  brightness_i,
  input  logic [hsvargb_pkg::BYTE_W-1:0]  alpha_i,
  output logic                            done_o,
  output logic [hsvargb_pkg::WORD_W-1:0]  argb_word_o
);
  import hsvargb_pkg::*;

  localparam int unsigned SpanW = $clog2((SECTOR_DEG << HueFracBits) + 1);

  logic                accept;

  logic                sec_valid;
  sector_e             sec_sector;
  logic [SpanW-1:0]    sec_weight;
  logic [CHROMA_W-1:0] sec_chroma;
  logic [CHROMA_W-1:0] sec_offset;
  logic [BYTE_W-1:0]   sec_alpha;

  logic                mix_valid;
  logic [CHROMA_W-1:0] mix_red;
  logic [CHROMA_W-1:0] mix_green;
  logic [CHROMA_W-1:0] mix_blue;
  logic [BYTE_W-1:0]   mix_alpha;

  // the pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // hue split, chroma and offset
  hsvargb_sector #(
    .HueFracBits(HueFracBits)
  ) u_sector (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .alpha_i      (alpha_i),
    .valid_o      (sec_valid),
    .sector_o     (sec_sector),
    .weight_o     (sec_weight),
    .chroma_o     (sec_chroma),
    .offset_o     (sec_offset),
    .alpha_o      (sec_alpha)
  );

  // second component and channel placement
  hsvargb_mix #(
    .HueFracBits(HueFracBits)
  ) u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sec_valid),
    .sector_i (sec_sector),
    .weight_i (sec_weight),
    .chroma_i (sec_chroma),
    .offset_i (sec_offset),
    .alpha_i  (sec_alpha),
    .valid_o  (mix_valid),
    .red_o    (mix_red),
    .green_o  (mix_green),
    .blue_o   (mix_blue),
    .alpha_o  (mix_alpha)
  );

  // divide by 255 and pack
  hsvargb_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (mix_valid),
    .red_i       (mix_red),
    .green_i     (mix_green),
    .blue_i      (mix_blue),
    .alpha_i     (mix_alpha),
    .valid_o     (done_o),
    .argb_word_o (argb_word_o)
  );

  // every result traces back to a transaction a fixed latency earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, PIPE_DEPTH))
    else $error("result strobe without matching transaction");

  // alpha reaches the top byte untouched
  a_alpha_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (argb_word_o[WORD_W-1 -: BYTE_W] == $past(alpha_i, PIPE_DEPTH)))
    else $error("alpha byte corrupted");

  // zero saturation gives grey at the brightness level
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(saturation_i, PIPE_DEPTH) == '0)) |->
      ((argb_word_o[23:16] == $past(brightness_i, PIPE_DEPTH)) &&
       (argb_word_o[15:8] == $past(brightness_i, PIPE_DEPTH)) &&
       (argb_word_o[7:0] == $past(brightness_i, PIPE_DEPTH))))
    else $error("unsaturated pixel not grey");

endmodule
